[rtl/core/rac_pkg.sv]
// Shared types, constants and the tone table for the 12-hour alarm clock.
// Used by every module of rtc_alarm_countdown; depends on nothing else.
`timescale 1ns / 1ps

package rac_pkg;

   localparam int HourWidth   = 4;
   localparam int MinuteWidth = 6;
   localparam int SecondWidth = 6;
   localparam int ToneWidth   = 19;
   localparam int CountWidth  = 16;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 6;

   localparam logic [6:0] SecsPerMin   = 7'd60;
   localparam logic [6:0] MinsPerHour  = 7'd60;
   localparam logic [4:0] HoursPerFrame = 5'd12;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CsrAlarmHour   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrAlarmMinute = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrAlarmEnable = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrRunMode     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrToneSelect  = 3'd4;

   // Item operations
   localparam logic OpTick = 1'b0;
   localparam logic OpLoad = 1'b1;

   localparam logic [2:0] ModeRun = 3'd0;

   typedef struct packed {
      logic [HourWidth-1:0]   alarm_hour;
      logic [MinuteWidth-1:0] alarm_minute;
      logic                   alarm_enable;
      logic [2:0]             run_mode;
      logic [1:0]             tone_select;
   } cfg_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic [HourWidth-1:0]   hour;
      logic [MinuteWidth-1:0] minute;
      logic [SecondWidth-1:0] second;
      logic                   fire;
   } entry_type;

   function automatic logic [ToneWidth-1:0] tone_period(input logic [1:0] sel);
      logic [ToneWidth-1:0] period;
      case (sel)
         2'd0:    period = 19'd25000;
         2'd1:    period = 19'd110000;
         2'd2:    period = 19'd210000;
         default: period = 19'd310000;
      endcase
      return period;
   endfunction

   // Seconds since the start of the 12-hour frame; hours are taken modulo 12.
   function automatic logic [CountWidth-1:0] frame_seconds(
      input logic [HourWidth-1:0]   hour,
      input logic [MinuteWidth-1:0] minute,
      input logic [SecondWidth-1:0] second
   );
      logic [HourWidth-1:0] hour_mod;
      hour_mod = ({1'b0, hour} >= HoursPerFrame) ? hour - 4'd12 : hour;
      return CountWidth'(hour_mod * 16'd3600) + CountWidth'(minute * 12'd60)
             + CountWidth'(second);
   endfunction

endpackage

[rtl/core/rac_front.sv]
// Front end of the alarm clock: holds the time of day, applies ticks and loads,
// and flags the alarm match on ticks. Depends on rac_pkg.
`timescale 1ns / 1ps

module rac_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                operation,
   input  logic [rac_pkg::HourWidth-1:0]       load_hour,
   input  logic [rac_pkg::MinuteWidth-1:0]     load_minute,
   input  logic [rac_pkg::SecondWidth-1:0]     load_second,
   input  rac_pkg::cfg_type                    cfg,
   output rac_pkg::entry_type                  entry
);

   logic [rac_pkg::HourWidth-1:0]   hour_ff,   hour_in;
   logic [rac_pkg::MinuteWidth-1:0] minute_ff, minute_in;
   logic [rac_pkg::SecondWidth-1:0] second_ff, second_in;
   logic [6:0] sec_inc;
   logic [6:0] min_inc;
   logic [4:0] hour_inc;
   logic       fire;

   assign sec_inc  = {1'b0, second_ff} + 7'd1;
   assign min_inc  = {1'b0, minute_ff} + 7'd1;
   assign hour_inc = {1'b0, hour_ff} + 5'd1;

   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      fire      = 1'b0;
      if (operation == rac_pkg::OpLoad) begin
         hour_in   = load_hour;
         minute_in = load_minute;
         second_in = load_second;
      end else begin
         second_in = sec_inc[5:0];
         if (sec_inc >= rac_pkg::SecsPerMin) begin
            second_in = '0;
            minute_in = min_inc[5:0];
            if (min_inc >= rac_pkg::MinsPerHour) begin
               minute_in = '0;
               hour_in   = (hour_inc > rac_pkg::HoursPerFrame) ? 4'd1 : hour_inc[3:0];
            end
         end
         fire = cfg.alarm_enable && (hour_in == cfg.alarm_hour)
                && (minute_in == cfg.alarm_minute) && (second_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff   <= 4'd12;
         minute_ff <= '0;
         second_ff <= '0;
      end else if (accept) begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
      end
   end

   assign entry.hour   = hour_in;
   assign entry.minute = minute_in;
   assign entry.second = second_in;
   assign entry.fire   = fire;

endmodule

[rtl/core/rac_queue.sv]
// Two-entry queue of classified items between the front and back ends.
// Depends on rac_pkg.
`timescale 1ns / 1ps

module rac_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rac_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output rac_pkg::entry_type head
);

   rac_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/rac_back.sv]
// Back end of the alarm clock: works out the countdown to the alarm, keeps the
// latched total and holds the result register. Depends on rac_pkg.
`timescale 1ns / 1ps

module rac_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 not_empty,
   input  rac_pkg::entry_type                   head,
   output logic                                 pop,
   input  rac_pkg::cfg_type                     cfg,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rac_pkg::HourWidth-1:0]        rsp_hours,
   output logic [rac_pkg::MinuteWidth-1:0]      rsp_minutes,
   output logic [rac_pkg::SecondWidth-1:0]      rsp_seconds,
   output logic                                 rsp_alarm_fire,
   output logic [rac_pkg::ToneWidth-1:0]        rsp_tone_period,
   output logic [rac_pkg::CountWidth-1:0]       rsp_remaining_seconds,
   output logic [rac_pkg::CountWidth-1:0]       rsp_total_seconds
);

   logic                              valid_ff;
   logic [rac_pkg::CountWidth-1:0]    total_ff, total_in;
   logic [rac_pkg::CountWidth-1:0]    remain_in;
   logic [rac_pkg::CountWidth-1:0]    now_s;
   logic [rac_pkg::CountWidth-1:0]    alarm_s;
   rac_pkg::entry_type                out_ff;
   logic [rac_pkg::ToneWidth-1:0]     tone_ff;
   logic [rac_pkg::CountWidth-1:0]    remain_ff;

   assign pop = not_empty && (!valid_ff || rsp_ready);

   assign now_s   = rac_pkg::frame_seconds(head.hour, head.minute, head.second);
   assign alarm_s = rac_pkg::frame_seconds(cfg.alarm_hour, cfg.alarm_minute, '0);

   always_comb begin
      remain_in = '0;
      total_in  = '0;
      if (cfg.run_mode == rac_pkg::ModeRun && cfg.alarm_enable) begin
         remain_in = (alarm_s > now_s) ? alarm_s - now_s : '0;
         total_in  = (total_ff == '0 && remain_in != '0) ? remain_in : total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            total_ff <= total_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff    <= head;
         tone_ff   <= head.fire ? rac_pkg::tone_period(cfg.tone_select) : '0;
         remain_ff <= remain_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_hours             = out_ff.hour;
   assign rsp_minutes           = out_ff.minute;
   assign rsp_seconds           = out_ff.second;
   assign rsp_alarm_fire        = out_ff.fire;
   assign rsp_tone_period       = tone_ff;
   assign rsp_remaining_seconds = remain_ff;
   assign rsp_total_seconds     = total_ff;

endmodule

[rtl/core/rtc_alarm_countdown.sv]
// Top level of the 12-hour real-time clock with alarm and countdown.
// Depends on rac_pkg, rac_front, rac_queue and rac_back.
`timescale 1ns / 1ps

// The block keeps a 12-hour time of day. Each request transfer is either a
// one-second tick or a load of hour, minute and second, and yields exactly one
// response transfer with the new time, an alarm flag with its tone period, and
// the countdown to the alarm together with the latched countdown total. The
// block takes one request every clock cycle while the queue has room; a
// response is registered first in a queue slot and then in the output
// register, and the two-entry queue lets the request side keep going
// for a while when the response side stalls. Configuration registers are
// written through the csr_ port at any cycle with csr_we high and take effect
// at once; they should be changed only while no request is in flight.

module rtc_alarm_countdown (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [rac_pkg::HourWidth-1:0]       req_load_hour,
   input  logic [rac_pkg::MinuteWidth-1:0]     req_load_minute,
   input  logic [rac_pkg::SecondWidth-1:0]     req_load_second,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rac_pkg::HourWidth-1:0]       rsp_hours,
   output logic [rac_pkg::MinuteWidth-1:0]     rsp_minutes,
   output logic [rac_pkg::SecondWidth-1:0]     rsp_seconds,
   output logic                                rsp_alarm_fire,
   output logic [rac_pkg::ToneWidth-1:0]       rsp_tone_period,
   output logic [rac_pkg::CountWidth-1:0]      rsp_remaining_seconds,
   output logic [rac_pkg::CountWidth-1:0]      rsp_total_seconds,
   // configuration write port
   input  logic                                csr_we,
   input  logic [rac_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [rac_pkg::CsrDataWidth-1:0]    csr_wdata
);

   rac_pkg::cfg_type   cfg_ff;
   rac_pkg::entry_type front_entry;
   rac_pkg::entry_type queue_head;
   logic               accept;
   logic               queue_full;
   logic               queue_not_empty;
   logic               queue_pop;

   // Configuration registers. Unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_hour   <= 4'd6;
         cfg_ff.alarm_minute <= '0;
         cfg_ff.alarm_enable <= 1'b1;
         cfg_ff.run_mode     <= rac_pkg::ModeRun;
         cfg_ff.tone_select  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rac_pkg::CsrAlarmHour:   cfg_ff.alarm_hour   <= csr_wdata[3:0];
            rac_pkg::CsrAlarmMinute: cfg_ff.alarm_minute <= csr_wdata[5:0];
            rac_pkg::CsrAlarmEnable: cfg_ff.alarm_enable <= csr_wdata[0];
            rac_pkg::CsrRunMode:     cfg_ff.run_mode     <= csr_wdata[2:0];
            rac_pkg::CsrToneSelect:  cfg_ff.tone_select  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // A request is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Front end: updates the time and flags an alarm match on a tick as the item arrives.
   rac_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .load_hour   (req_load_hour),
      .load_minute (req_load_minute),
      .load_second (req_load_second),
      .cfg         (cfg_ff),
      .entry       (front_entry)
   );

   rac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .head       (queue_head)
   );

   // Back end: countdown, latched total and the response register.
   rac_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .not_empty             (queue_not_empty),
      .head                  (queue_head),
      .pop                   (queue_pop),
      .cfg                   (cfg_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_hours             (rsp_hours),
      .rsp_minutes           (rsp_minutes),
      .rsp_seconds           (rsp_seconds),
      .rsp_alarm_fire        (rsp_alarm_fire),
      .rsp_tone_period       (rsp_tone_period),
      .rsp_remaining_seconds (rsp_remaining_seconds),
      .rsp_total_seconds     (rsp_total_seconds)
   );

endmodule
